### src/html_tok_pkg.sv
// Package for the HTML tag and text tokenizer: word types, token kinds,
// delimiter characters and the helper that builds one result word.
// Used by html_tag_text_tokenizer; depends on nothing else.
`default_nettype none

package html_tok_pkg;

    // Token kinds carried in token_kind.
    localparam logic [2:0] KIND_TEXT  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_END   = 3'd2;
    localparam logic [2:0] KIND_EOF   = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    // Characters that steer the scanner.
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Depth of the result queue and its pointer and count widths.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_end;
    } in_word_t;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] char_byte;
        logic       char_valid;
        logic       token_last;
    } out_word_t;

    // The character field reads as zero whenever no character is carried.
    function automatic out_word_t make_word(input logic [2:0] kind,
                                            input logic [7:0] ch,
                                            input logic       valid,
                                            input logic       last);
        out_word_t w;
        w.token_kind = kind;
        w.char_byte  = valid ? ch : 8'd0;
        w.char_valid = valid;
        w.token_last = last;
        return w;
    endfunction

endpackage

`default_nettype wire

### src/html_tag_text_tokenizer.sv
// Top level of the HTML tag and text tokenizer: scanner state, held
// character and a four-word result queue.
// Depends on html_tok_pkg.
`default_nettype none

// Takes one document byte per cycle while in_ready is high, or an
// end-of-document word, and gives the characters of text runs, start-tag
// names and end-tag names one word at a time, each with its kind and a last
// mark. One character is held back so that the last mark can be set when
// the delimiter arrives; a byte therefore shows up on the output only once
// the following byte (or the end word) has been taken. Results enter a
// four-word queue whose head drives the output, so the results of a word
// are registered before they can appear. in_ready is high while at most two
// words are queued; an ordinary byte yields at most one word, so with a
// ready consumer the block sustains one input word per cycle. The end word
// yields end of file, after any pending text or an error, and restarts the
// scanner.
module html_tag_text_tokenizer
    import html_tok_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_data
);

    typedef enum logic [2:0] {
        MODE_DATA,
        MODE_TAG_OPEN,
        MODE_START,
        MODE_END,
        MODE_BANG,
        MODE_SKIP
    } scan_mode_t;

    scan_mode_t       mode_reg, mode_next;
    logic [7:0]       held_byte_reg, held_byte_next;
    logic             held_valid_reg, held_valid_next;
    logic [1:0]       held_kind_reg, held_kind_next;

    out_word_t        queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             in_fire;
    logic             out_fire;
    logic [7:0]       b;
    logic             is_delim;
    logic [1:0]       n_res;
    out_word_t        res0;
    out_word_t        res1;
    out_word_t        held_word;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign in_ready  = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign in_fire   = in_valid & in_ready;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid & out_ready;
    assign out_data  = queue_reg[rd_ptr_reg];

    assign b        = in_data.data_byte;
    assign is_delim = (b == CH_SPACE) || (b == CH_SLASH) || (b == CH_GT);

    // Scanner step: at most two result words and the next scanner state.
    always_comb
    begin
        mode_next       = mode_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_kind_next  = held_kind_reg;
        n_res           = 2'd0;
        held_word       = make_word({1'b0, held_kind_reg}, held_byte_reg, 1'b1, 1'b0);
        res0            = held_word;
        res1            = make_word(KIND_EOF, 8'd0, 1'b0, 1'b1);

        if (in_data.is_end)
        begin
            if (mode_reg == MODE_DATA)
            begin
                if (held_valid_reg)
                begin
                    res0       = held_word;
                    res0.token_last = 1'b1;
                    n_res      = 2'd2;
                end
                else
                begin
                    res0  = make_word(KIND_EOF, 8'd0, 1'b0, 1'b1);
                    n_res = 2'd1;
                end
            end
            else
            begin
                // Any name character held inside a cut-off tag is dropped.
                res0  = make_word(KIND_ERROR, 8'd0, 1'b0, 1'b1);
                n_res = 2'd2;
            end
            mode_next       = MODE_DATA;
            held_byte_next  = 8'd0;
            held_valid_next = 1'b0;
            held_kind_next  = 2'd0;
        end
        else
        begin
            case (mode_reg)
                MODE_TAG_OPEN, MODE_START:
                begin
                    if (mode_reg == MODE_TAG_OPEN && b == CH_SLASH)
                    begin
                        mode_next = MODE_END;
                    end
                    else if (mode_reg == MODE_TAG_OPEN && b == CH_BANG)
                    begin
                        mode_next = MODE_BANG;
                    end
                    else if (is_delim)
                    begin
                        if (held_valid_reg)
                        begin
                            res0.token_last = 1'b1;
                        end
                        else
                        begin
                            res0 = make_word(KIND_START, 8'd0, 1'b0, 1'b1);
                        end
                        n_res           = 2'd1;
                        held_valid_next = 1'b0;
                        mode_next       = (b == CH_GT) ? MODE_DATA : MODE_SKIP;
                    end
                    else
                    begin
                        n_res           = held_valid_reg ? 2'd1 : 2'd0;
                        held_byte_next  = b;
                        held_kind_next  = KIND_START[1:0];
                        held_valid_next = 1'b1;
                        mode_next       = MODE_START;
                    end
                end
                MODE_END:
                begin
                    if (b == CH_GT)
                    begin
                        if (held_valid_reg)
                        begin
                            res0.token_last = 1'b1;
                        end
                        else
                        begin
                            res0 = make_word(KIND_END, 8'd0, 1'b0, 1'b1);
                        end
                        n_res           = 2'd1;
                        held_valid_next = 1'b0;
                        mode_next       = MODE_DATA;
                    end
                    else
                    begin
                        n_res           = held_valid_reg ? 2'd1 : 2'd0;
                        held_byte_next  = b;
                        held_kind_next  = KIND_END[1:0];
                        held_valid_next = 1'b1;
                    end
                end
                MODE_BANG, MODE_SKIP:
                begin
                    if (b == CH_GT)
                    begin
                        mode_next = MODE_DATA;
                    end
                end
                default:
                begin
                    mode_next = MODE_DATA;
                    if (b == CH_LT)
                    begin
                        res0.token_last = 1'b1;
                        n_res           = held_valid_reg ? 2'd1 : 2'd0;
                        held_valid_next = 1'b0;
                        mode_next       = MODE_TAG_OPEN;
                    end
                    else
                    begin
                        n_res           = held_valid_reg ? 2'd1 : 2'd0;
                        held_byte_next  = b;
                        held_kind_next  = KIND_TEXT[1:0];
                        held_valid_next = 1'b1;
                    end
                end
            endcase
        end
    end

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_fire)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(n_res);
            count_next  = count_next + CNT_W'(n_res);
        end
        if (out_fire)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            count_next  = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_DATA;
            held_valid_reg <= 1'b0;
            held_kind_reg  <= 2'd0;
            held_byte_reg  <= 8'd0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg       <= mode_next;
                held_valid_reg <= held_valid_next;
                held_kind_reg  <= held_kind_next;
                held_byte_reg  <= held_byte_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue entries hold payload only; the count says which are live.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (in_fire && n_res != 2'd0 && wr_ptr_reg == PTR_W'(i))
            begin
                queue_reg[i] <= res0;
            end
            else if (in_fire && n_res == 2'd2 && wr_ptr_plus1 == PTR_W'(i))
            begin
                queue_reg[i] <= res1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue count above its depth");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.is_end |=> mode_reg == MODE_DATA && !held_valid_reg)
        else $error("scanner not restarted after end of document");

    a_end_gives_words: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.is_end |=> out_valid)
        else $error("end of document left no result queued");

    a_start_kind: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg && mode_reg == MODE_START |-> held_kind_reg == KIND_START[1:0])
        else $error("held character in a start-tag name has the wrong kind");

    a_queue_pointers: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg == rd_ptr_reg + PTR_W'(count_reg))
        else $error("queue pointers disagree with the count");
`endif

endmodule

`default_nettype wire
